>>> hw/rtl/i2cm_pkg.sv
// i2cm_pkg: shared types, command and phase-op codes, sequence tables
// for the i2c bit-level master. no dependencies.
`timescale 1ns / 1ps

package i2cm_pkg;

    // command codes carried on func
    localparam logic [3:0] CmdIdle  = 4'd0;
    localparam logic [3:0] CmdStart = 4'd1;
    localparam logic [3:0] CmdStop  = 4'd2;
    localparam logic [3:0] CmdSend  = 4'd3;
    localparam logic [3:0] CmdRead  = 4'd4;
    localparam logic [3:0] CmdAck   = 4'd5;
    localparam logic [3:0] CmdNack  = 4'd6;
    localparam logic [3:0] CmdWait  = 4'd7;
    localparam logic [3:0] CmdCheck = 4'd8;

    // per-phase line operations
    localparam logic [3:0] OpStart0   = 4'd0;
    localparam logic [3:0] OpSda0     = 4'd1;
    localparam logic [3:0] OpScl0     = 4'd2;
    localparam logic [3:0] OpStop0    = 4'd3;
    localparam logic [3:0] OpBitSda   = 4'd4;
    localparam logic [3:0] OpScl1     = 4'd5;
    localparam logic [3:0] OpScl0Shft = 4'd6;
    localparam logic [3:0] OpRdHigh   = 4'd7;
    localparam logic [3:0] OpRdLow    = 4'd8;
    localparam logic [3:0] OpSda1     = 4'd9;
    localparam logic [3:0] OpAckHigh  = 4'd10;

    localparam logic [7:0] PhaseTicksReset = 8'd10;
    localparam int unsigned QueueDepth = 2;

    // one classified word between front and back
    typedef struct packed {
        logic [3:0] cmd;
        logic [7:0] tx;
        logic       sda;
    } item_t;

    // phases in each command
    function automatic logic [5:0] phase_total(input logic [3:0] cmd);
        logic [5:0] n;
        begin
            unique case (cmd)
                CmdStart: n = 6'd3;
                CmdStop:  n = 6'd1;
                CmdSend:  n = 6'd24;
                CmdRead:  n = 6'd16;
                CmdAck:   n = 6'd3;
                CmdNack:  n = 6'd3;
                CmdWait:  n = 6'd3;
                CmdCheck: n = 6'd32;
                default:  n = 6'd0;
            endcase
            return n;
        end
    endfunction

    // three-phase sequences, selected by the phase position mod 3
    function automatic logic [3:0] seq_start(input logic [1:0] m);
        begin
            case (m)
                2'd0:    return OpStart0;
                2'd1:    return OpSda0;
                default: return OpScl0;
            endcase
        end
    endfunction

    function automatic logic [3:0] seq_send(input logic [1:0] m);
        begin
            case (m)
                2'd0:    return OpBitSda;
                2'd1:    return OpScl1;
                default: return OpScl0Shft;
            endcase
        end
    endfunction

    function automatic logic [3:0] seq_wait(input logic [1:0] m);
        begin
            case (m)
                2'd0:    return OpSda1;
                2'd1:    return OpAckHigh;
                default: return OpScl0;
            endcase
        end
    endfunction

    // line operation of a phase; m is idx mod 3, kept as a counter
    function automatic logic [3:0] op_of(input logic [3:0] cmd, input logic [5:0] idx,
                                         input logic [1:0] m);
        logic [1:0] m2;
        logic [3:0] op;
        begin
            // (idx - 1) mod 3 for the chained check-device sequence
            case (m)
                2'd0:    m2 = 2'd2;
                2'd1:    m2 = 2'd0;
                default: m2 = 2'd1;
            endcase
            unique case (cmd)
                CmdStart: op = seq_start(m);
                CmdStop:  op = OpStop0;
                CmdSend:  op = seq_send(m);
                CmdRead:  op = idx[0] ? OpRdLow : OpRdHigh;
                CmdAck:   op = (m == 2'd0) ? OpSda0 : ((m == 2'd1) ? OpScl1 : OpScl0);
                CmdNack:  op = (m == 2'd0) ? OpSda1 : ((m == 2'd1) ? OpScl1 : OpScl0);
                CmdWait:  op = seq_wait(m);
                default:
                begin
                    if (idx == 6'd0 || idx >= 6'd31)
                        op = OpStop0;
                    else if (idx <= 6'd3)
                        op = seq_start(m2);
                    else if (idx <= 6'd27)
                        op = seq_send(m2);
                    else
                        op = seq_wait(m2);
                end
            endcase
            return op;
        end
    endfunction

endpackage

>>> hw/rtl/i2cm_if.sv
// i2cm_in_if / i2cm_out_if: valid-ready channels for tick words and results
// no dependencies
`timescale 1ns / 1ps

interface i2cm_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] func;
    logic [7:0] tx_byte;
    logic       sda_in;

    modport source (output valid, output func, output tx_byte, output sda_in, input ready);
    modport sink   (input valid, input func, input tx_byte, input sda_in, output ready);
endinterface

interface i2cm_out_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_bit;

    modport source (output valid, output scl_level, output sda_level, output busy_res,
                    output done_res, output rx_byte, output ack_bit, input ready);
    modport sink   (input valid, input scl_level, input sda_level, input busy_res,
                    input done_res, input rx_byte, input ack_bit, output ready);
endinterface

>>> hw/rtl/i2cm_front.sv
// i2cm_front: accepts tick words and classifies func into a command code
// depends on i2cm_pkg, i2cm_in_if
`timescale 1ns / 1ps

module i2cm_front (
    i2cm_in_if.sink          in_ch,
    output logic             push,
    output i2cm_pkg::item_t  push_item,
    input  logic             push_ready
);
    import i2cm_pkg::*;

    // accept whenever the queue has room
    assign in_ch.ready = push_ready;
    assign push        = in_ch.valid;

    // func codes outside the command set behave as a plain tick
    always_comb
    begin
        push_item.tx  = in_ch.tx_byte;
        push_item.sda = in_ch.sda_in;
        unique case (in_ch.func) inside
            CmdStart, CmdStop, CmdSend, CmdRead, CmdAck, CmdNack, CmdWait, CmdCheck:
                push_item.cmd = in_ch.func;
            default:
                push_item.cmd = CmdIdle;
        endcase
    end
endmodule

>>> hw/rtl/i2cm_queue.sv
// i2cm_queue: short fifo of classified words between front and back
// depends on i2cm_pkg
`timescale 1ns / 1ps

module i2cm_queue #(
    parameter int unsigned Depth = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  i2cm_pkg::item_t  push_item,
    output logic             push_ready,
    output logic             pop_valid,
    output i2cm_pkg::item_t  pop_item,
    input  logic             pop
);
    import i2cm_pkg::*;

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    item_t            slot_reg [Depth];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != FullCnt);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end
endmodule

>>> hw/rtl/i2cm_engine.sv
// i2cm_engine: back end, steps the phase sequencer one word per cycle while words
// are queued and out_ch is not stalled, and registers each result. depends on i2cm_pkg, i2cm_out_if
`timescale 1ns / 1ps

module i2cm_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [7:0]       cfg_wdata,
    input  logic             pop_valid,
    input  i2cm_pkg::item_t  pop_item,
    output logic             pop,
    i2cm_out_if.source       out_ch
);
    import i2cm_pkg::*;

    logic [7:0] phase_ticks_reg;
    logic [3:0] active_cmd_reg, active_cmd_next;
    logic [5:0] phase_index_reg, phase_index_next;
    logic [1:0] phase_mod3_reg, phase_mod3_next;
    logic [2:0] bit_index_reg, bit_index_next;
    logic [7:0] tick_count_reg, tick_count_next;
    logic [7:0] shift_reg, shift_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic [7:0] rx_reg, rx_next;
    logic       ack_reg, ack_next;
    logic       done_next;

    logic       out_valid_reg;
    logic       out_scl_reg, out_sda_reg, out_busy_reg, out_done_reg, out_ack_reg;
    logic [7:0] out_rx_reg;

    // take a word when the result register is free or being drained
    assign pop = pop_valid && (!out_valid_reg || out_ch.ready);

    // sequencer step for one tick word
    always_comb
    begin
        logic [3:0] op;
        logic [7:0] tick_sum;

        active_cmd_next  = active_cmd_reg;
        phase_index_next = phase_index_reg;
        phase_mod3_next  = phase_mod3_reg;
        bit_index_next   = bit_index_reg;
        tick_count_next  = tick_count_reg;
        shift_next       = shift_reg;
        scl_next         = scl_reg;
        sda_next         = sda_reg;
        rx_next          = rx_reg;
        ack_next         = ack_reg;
        done_next        = 1'b0;
        op               = OpStop0;
        tick_sum         = '0;

        // command launch while idle
        if (active_cmd_reg == CmdIdle && pop_item.cmd != CmdIdle)
        begin
            active_cmd_next  = pop_item.cmd;
            phase_index_next = '0;
            phase_mod3_next  = '0;
            tick_count_next  = '0;
            bit_index_next   = '0;
            shift_next       = (pop_item.cmd == CmdSend || pop_item.cmd == CmdCheck)
                               ? pop_item.tx : 8'd0;
        end

        if (active_cmd_next != CmdIdle)
        begin
            op = op_of(active_cmd_next, phase_index_next, phase_mod3_next);

            // line changes on the first tick of a phase
            if (tick_count_next == 8'd0)
            begin
                unique case (op) inside
                    OpStart0:
                    begin
                        sda_next = 1'b1;
                        scl_next = 1'b1;
                    end
                    OpSda0:           sda_next = 1'b0;
                    OpScl0, OpRdLow:  scl_next = 1'b0;
                    OpStop0:
                    begin
                        sda_next = 1'b0;
                        scl_next = 1'b1;
                    end
                    OpBitSda:         sda_next = shift_next[7];
                    OpScl1, OpRdHigh, OpAckHigh: scl_next = 1'b1;
                    OpScl0Shft:
                    begin
                        scl_next = 1'b0;
                        if (bit_index_next == 3'd7)
                            sda_next = 1'b1;
                        shift_next     = {shift_next[6:0], 1'b0};
                        bit_index_next = bit_index_next + 3'd1;
                    end
                    OpSda1:           sda_next = 1'b1;
                    default:          ;
                endcase
            end

            // phase end: sample sda, advance, maybe finish
            tick_sum = tick_count_next + 8'd1;
            if (tick_sum >= phase_ticks_reg)
            begin
                if (op == OpRdHigh)
                    shift_next = {shift_next[6:0], pop_item.sda};
                else if (op == OpAckHigh)
                    ack_next = pop_item.sda;
                tick_count_next  = '0;
                phase_index_next = phase_index_next + 6'd1;
                phase_mod3_next  = (phase_mod3_next == 2'd2) ? 2'd0 : phase_mod3_next + 2'd1;
                if (phase_index_next >= phase_total(active_cmd_next))
                begin
                    if (active_cmd_next == CmdStop || active_cmd_next == CmdAck
                        || active_cmd_next == CmdCheck)
                        sda_next = 1'b1;
                    if (active_cmd_next == CmdRead)
                        rx_next = shift_next;
                    active_cmd_next  = CmdIdle;
                    phase_index_next = '0;
                    done_next        = 1'b1;
                end
            end
            else
            begin
                tick_count_next = tick_sum;
            end
        end
    end

    // sequencer state and phase length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PhaseTicksReset;
            active_cmd_reg  <= CmdIdle;
            phase_index_reg <= '0;
            phase_mod3_reg  <= '0;
            bit_index_reg   <= '0;
            tick_count_reg  <= '0;
            shift_reg       <= '0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            rx_reg          <= '0;
            ack_reg         <= 1'b1;
        end
        else
        begin
            if (cfg_we)
                phase_ticks_reg <= cfg_wdata;
            if (pop)
            begin
                active_cmd_reg  <= active_cmd_next;
                phase_index_reg <= phase_index_next;
                phase_mod3_reg  <= phase_mod3_next;
                bit_index_reg   <= bit_index_next;
                tick_count_reg  <= tick_count_next;
                shift_reg       <= shift_next;
                scl_reg         <= scl_next;
                sda_reg         <= sda_next;
                rx_reg          <= rx_next;
                ack_reg         <= ack_next;
            end
        end
    end

    // result word valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    // result word payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_scl_reg  <= scl_next;
            out_sda_reg  <= sda_next;
            out_busy_reg <= (active_cmd_next != CmdIdle);
            out_done_reg <= done_next;
            out_rx_reg   <= rx_next;
            out_ack_reg  <= ack_next;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.scl_level = out_scl_reg;
    assign out_ch.sda_level = out_sda_reg;
    assign out_ch.busy_res  = out_busy_reg;
    assign out_ch.done_res  = out_done_reg;
    assign out_ch.rx_byte   = out_rx_reg;
    assign out_ch.ack_bit   = out_ack_reg;

    // a finishing word leaves the sequencer idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && done_next) |=> (active_cmd_reg == CmdIdle))
        else $error("sequencer not idle after done");

    // idle sequencer has its phase position cleared
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (active_cmd_reg == CmdIdle) |-> (phase_index_reg == 6'd0 && tick_count_reg == 8'd0))
        else $error("idle with stale phase state");

    // running command stays within its phase count
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        (active_cmd_reg != CmdIdle) |-> (phase_index_reg < phase_total(active_cmd_reg)))
        else $error("phase index beyond command length");

    // mod-3 tracker is zero while a running command is at phase index 0
    a_mod3_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (active_cmd_reg != CmdIdle && phase_index_reg == 6'd0) |-> (phase_mod3_reg == 2'd0))
        else $error("phase mod-3 tracker out of step");
endmodule

>>> hw/rtl/i2c_bit_level_master.sv
// i2c_bit_level_master: top level, front classifier, word queue, sequencer
// depends on i2cm_pkg, i2cm_if, i2cm_front, i2cm_queue, i2cm_engine
//
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    func[3:0], tx_byte[7:0], sda_in
//  out_ch    out  valid/ready    scl_level, sda_level, busy_res, done_res,
//                                rx_byte[7:0], ack_bit
//  cfg       in   cfg_we         cfg_wdata[7:0] = phase_ticks
//
// one tick word per clock sustained while out_ch is not stalled; an accepted word
// passes through a queue slot, then the sequencer step into the result register.
// the sequencer state register feeds back into its own next-state logic.
// reset releases both lines, clears the queue, sets phase_ticks to 10.
// a stall on out_ch backs up through the queue into in_ch ready.
`timescale 1ns / 1ps

module i2c_bit_level_master #(
    parameter int unsigned QDepth = i2cm_pkg::QueueDepth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    i2cm_in_if.sink     in_ch,
    i2cm_out_if.source  out_ch
);
    import i2cm_pkg::*;

    logic  push, push_ready, pop_valid, pop;
    item_t push_item, pop_item;

    // classify incoming words
    i2cm_front u_front (
        .in_ch      (in_ch),
        .push       (push),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    // decouple front from sequencer
    i2cm_queue #(
        .Depth (QDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop        (pop)
    );

    // phase sequencer and result register
    i2cm_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .pop       (pop),
        .out_ch    (out_ch)
    );
endmodule
